### hw/rtl/sobel_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Sobel edge detector package
// Shared constants and types for the Sobel edge detector.
// ============================================================================
package sobel_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_CAP    = 4096;
    localparam int IN_ROW_CAP    = 8191;
    localparam int ADDR_W        = 5;

    localparam logic [ADDR_W-1:0] REG_WIDTH     = 5'd0;
    localparam logic [ADDR_W-1:0] REG_HEIGHT    = 5'd4;
    localparam logic [ADDR_W-1:0] REG_MODE      = 5'd8;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 5'd12;
    localparam logic [ADDR_W-1:0] REG_RATIO     = 5'd16;

    localparam logic [1:0] MODE_GX  = 2'd0;
    localparam logic [1:0] MODE_GY  = 2'd1;
    localparam logic [1:0] MODE_MAG = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       drain;
    } pix_beat_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_last;
    } edge_beat_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [12:0] frame_height;
        logic [1:0]  edge_mode;
        logic [7:0]  edge_threshold;
        logic [9:0]  gain_ratio;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;       // latch the frame-last flag of the window result
        logic sqrt_start; // begin the root iteration
        logic sqrt_step;  // one root iteration
        logic finish;     // compute the final value into the output register
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
    } status_t;

endpackage

### hw/rtl/sobel_stream_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Sobel stream interface
// Valid/ready channel carrying a payload of parameterised type.
// ============================================================================
interface sobel_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sobel_edge_detector_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Sobel edge detector top level
// 3x3 Sobel edge filter over a raster pixel stream with APB configuration.
// ============================================================================
// Pixels enter on the in_ch sink channel as {pixel, drain} beats in raster
// order; results leave on out_ch as {edge_value, frame_last} beats. The
// result for a pixel appears after the pixel one row and one column later
// is taken, so the host sends frame_width+1 drain beats after each frame.
// Each beat is processed by a controller that walks it through the line
// stores, the gradient stage and a two-bit-per-step square root unit; a
// beat that gives a result also passes through the operand load and the
// nine root iterations. out_ch valid is registered and rises once the
// result is in the output register. When out_ch stalls, the result is
// held in the output register while the next beat is processed; a second
// result waits until the first has been delivered, and no beat is taken
// meanwhile. Reset returns the registers to width 640, height 480, mode 2,
// threshold 0, ratio 0 and restarts the frame; line store contents are left
// undefined and are masked at the frame edge. The user is bound to write
// configuration over APB only while idle; the block does not enforce it.
// ============================================================================
module sobel_edge_detector_top #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [sobel_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sobel_stream_if.sink   in_ch,
    sobel_stream_if.source out_ch
);
    sobel_pkg::cfg_t    cfg_reg;
    sobel_pkg::cmd_t    cmd;
    sobel_pkg::status_t status;
    logic               in_fire, have_result;
    logic               lines_valid_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= 11'd640;
            cfg_reg.frame_height   <= 13'd480;
            cfg_reg.edge_mode      <= sobel_pkg::MODE_MAG;
            cfg_reg.edge_threshold <= 8'd0;
            cfg_reg.gain_ratio     <= 10'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                sobel_pkg::REG_WIDTH:     cfg_reg.frame_width    <= pwdata[10:0];
                sobel_pkg::REG_HEIGHT:    cfg_reg.frame_height   <= pwdata[12:0];
                sobel_pkg::REG_MODE:      cfg_reg.edge_mode      <= pwdata[1:0];
                sobel_pkg::REG_THRESHOLD: cfg_reg.edge_threshold <= pwdata[7:0];
                sobel_pkg::REG_RATIO:     cfg_reg.gain_ratio     <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            sobel_pkg::REG_WIDTH:     prdata = {21'd0, cfg_reg.frame_width};
            sobel_pkg::REG_HEIGHT:    prdata = {19'd0, cfg_reg.frame_height};
            sobel_pkg::REG_MODE:      prdata = {30'd0, cfg_reg.edge_mode};
            sobel_pkg::REG_THRESHOLD: prdata = {24'd0, cfg_reg.edge_threshold};
            sobel_pkg::REG_RATIO:     prdata = {22'd0, cfg_reg.gain_ratio};
            default:                  prdata = 32'd0;
        endcase
    end

    // Line data is unused until the first read returns.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_valid_reg <= 1'b0;
        end
        else
        begin
            lines_valid_reg <= 1'b1;
        end
    end

    sobel_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_fire(in_fire),
        .have_result(have_result),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .status(status)
    );

    sobel_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_fire(in_fire), .in_pixel(in_ch.data.pixel), .in_drain(in_ch.data.drain),
        .lines_valid(lines_valid_reg), .have_result(have_result),
        .cmd(cmd), .status(status),
        .edge_value(out_ch.data.edge_value), .frame_last(out_ch.data.frame_last)
    );
endmodule

### hw/rtl/sobel_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Sobel generic RAM
// Single-port RAM with synchronous write and registered read.
// ============================================================================
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/sobel_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// Sobel datapath
// Line stores, window, position counters, gradient and strength arithmetic.
// ============================================================================
module sobel_datapath #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sobel_pkg::cfg_t    cfg,
    input  logic               in_fire,
    input  logic [7:0]         in_pixel,
    input  logic               in_drain,
    input  logic               lines_valid,
    output logic               have_result,
    input  sobel_pkg::cmd_t    cmd,
    output sobel_pkg::status_t status,
    output logic [7:0]         edge_value,
    output logic               frame_last
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0] w_clamp;
    logic [12:0]   h_clamp;
    logic [WW-1:0] wm1;
    logic [12:0]   hm1;

    always_comb
    begin
        if (cfg.frame_width == 11'd0)
        begin
            w_clamp = WW'(1);
        end
        else if ({21'd0, cfg.frame_width} > 32'(MAX_WIDTH))
        begin
            w_clamp = WW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = WW'(cfg.frame_width);
        end
        if (cfg.frame_height == 13'd0)
        begin
            h_clamp = 13'd1;
        end
        else if (cfg.frame_height > 13'(sobel_pkg::HEIGHT_CAP))
        begin
            h_clamp = 13'(sobel_pkg::HEIGHT_CAP);
        end
        else
        begin
            h_clamp = cfg.frame_height;
        end
        wm1 = w_clamp - WW'(1);
        hm1 = h_clamp - 13'd1;
    end

    // Captured input; line reads arrive in the cycle after the capture.
    logic [WW-1:0] in_col_reg;
    logic [12:0]   in_row_reg;
    logic [WW-1:0] out_col_reg;
    logic [12:0]   out_row_reg;
    logic [7:0]    pix_reg;
    logic [CW-1:0] addr_reg;
    logic          p1_reg;
    logic          ready_p1_reg;
    logic          last_p1_reg;
    logic          mtop_reg, mbot_reg, mlft_reg, mrgt_reg;
    logic [7:0]    up_rd, lo_rd;
    logic [7:0]    win_reg [9];
    logic [7:0]    pix_d;

    logic          ready_now, last_now;
    logic [CW-1:0] addr;
    logic [7:0]    pix_in;

    assign pix_in    = in_drain ? 8'd0 : in_pixel;
    assign ready_now = (in_row_reg >= 13'd2) || (in_row_reg == 13'd1 && in_col_reg >= WW'(1));
    assign last_now  = (out_row_reg >= hm1) && (out_col_reg >= wm1);
    assign addr      = in_fire ? in_col_reg[CW-1:0] : addr_reg;

    // The line stores are read at the accepting edge and written at the next
    // edge, when the old lower entry has come back and moves up.
    sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk), .we(p1_reg), .addr(addr), .wdata(lo_rd), .rdata(up_rd)
    );

    sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lower (
        .clk(clk), .we(p1_reg), .addr(addr), .wdata(pix_reg), .rdata(lo_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            p1_reg       <= 1'b0;
            ready_p1_reg <= 1'b0;
            last_p1_reg  <= 1'b0;
        end
        else
        begin
            p1_reg <= in_fire;
            if (in_fire)
            begin
                ready_p1_reg <= ready_now;
                last_p1_reg  <= ready_now && last_now;
                if (ready_now && last_now)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else
                begin
                    if (in_col_reg + WW'(1) >= w_clamp)
                    begin
                        in_col_reg <= '0;
                        if (in_row_reg < 13'(sobel_pkg::IN_ROW_CAP))
                        begin
                            in_row_reg <= in_row_reg + 13'd1;
                        end
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + WW'(1);
                    end
                    if (ready_now)
                    begin
                        if (out_col_reg >= wm1)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 13'd1;
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + WW'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_reg  <= pix_in;
            addr_reg <= in_col_reg[CW-1:0];
            mtop_reg <= out_row_reg == 13'd0;
            mbot_reg <= out_row_reg >= hm1;
            mlft_reg <= out_col_reg == '0;
            mrgt_reg <= out_col_reg >= wm1;
        end
    end

    assign pix_d = pix_reg;

    // Window shift once the line data is back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else if (p1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= lines_valid ? up_rd : 8'd0;
            win_reg[5] <= lines_valid ? lo_rd : 8'd0;
            win_reg[8] <= pix_d;
        end
    end

    // Stage 2: masked gradients.
    logic       s2_reg;
    logic       s2_last_reg;
    logic       mt2, mb2, ml2, mr2;
    logic [7:0] ax_reg, ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= 1'b0;
        end
        else
        begin
            s2_reg <= p1_reg && ready_p1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_reg)
        begin
            mt2         <= mtop_reg;
            mb2         <= mbot_reg;
            ml2         <= mlft_reg;
            mr2         <= mrgt_reg;
            s2_last_reg <= last_p1_reg;
        end
    end

    logic [7:0]         e [9];
    logic signed [11:0] gx, gy;
    logic [11:0]        agx, agy;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            e[i] = win_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (mt2) e[i] = 8'd0;
            if (mb2) e[6+i] = 8'd0;
            if (ml2) e[i*3] = 8'd0;
            if (mr2) e[i*3+2] = 8'd0;
        end
        gx = $signed({4'd0, e[2]}) + $signed({3'd0, e[5], 1'b0}) + $signed({4'd0, e[8]})
           - $signed({4'd0, e[0]}) - $signed({3'd0, e[3], 1'b0}) - $signed({4'd0, e[6]});
        gy = $signed({4'd0, e[6]}) + $signed({3'd0, e[7], 1'b0}) + $signed({4'd0, e[8]})
           - $signed({4'd0, e[0]}) - $signed({3'd0, e[1], 1'b0}) - $signed({4'd0, e[2]});
        agx = gx[11] ? 12'(-gx) : 12'(gx);
        agy = gy[11] ? 12'(-gy) : 12'(gy);
    end

    assign have_result = s2_reg;

    always_ff @(posedge clk)
    begin
        if (s2_reg)
        begin
            ax_reg <= (agx > 12'd255) ? 8'd255 : agx[7:0];
            ay_reg <= (agy > 12'd255) ? 8'd255 : agy[7:0];
        end
    end

    // Square root over the sum of squares, two bits per step.
    logic [17:0] sq_reg;
    logic [16:0] rem_reg;
    logic [8:0]  root_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;

    logic [18:0] trial;
    logic [18:0] rem_sh;

    assign rem_sh = {rem_reg, sq_reg[17:16]};
    assign trial  = {8'd0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            cnt_reg <= 4'd9;
        end
        else if (cmd.sqrt_step && cnt_reg != 4'd0)
        begin
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    assign status.sqrt_done = cnt_reg == 4'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            last_reg <= s2_last_reg;
        end
        if (cmd.sqrt_start)
        begin
            sq_reg   <= {10'd0, ax_reg} * {10'd0, ax_reg} + {10'd0, ay_reg} * {10'd0, ay_reg};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step && cnt_reg != 4'd0)
        begin
            sq_reg <= {sq_reg[15:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= 17'(rem_sh - trial);
                root_reg <= {root_reg[7:0], 1'b1};
            end
            else
            begin
                rem_reg  <= 17'(rem_sh);
                root_reg <= {root_reg[7:0], 1'b0};
            end
        end
    end

    // Strength scaling and output register.
    logic [10:0] factor;
    logic [19:0] prod;
    logic [11:0] q;
    logic [8:0]  m;

    always_comb
    begin
        m = root_reg;
        if (m > {1'b0, cfg.edge_threshold})
        begin
            factor = 11'd256 + {1'b0, cfg.gain_ratio};
        end
        else if (cfg.gain_ratio <= 10'd256)
        begin
            factor = 11'd256 - {1'b0, cfg.gain_ratio};
        end
        else
        begin
            factor = {1'b0, cfg.gain_ratio} - 11'd256;
        end
        prod = {11'd0, m} * {9'd0, factor};
        q    = prod[19:8];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            frame_last <= last_reg;
            case (cfg.edge_mode)
                sobel_pkg::MODE_GX: edge_value <= ax_reg;
                sobel_pkg::MODE_GY: edge_value <= ay_reg;
                default:            edge_value <= (q > 12'd255) ? 8'd255 : q[7:0];
            endcase
        end
    end
endmodule

### hw/rtl/sobel_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// Sobel controller
// Sequences each result through the root unit and holds the output beat.
// ============================================================================
module sobel_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               in_fire,
    input  logic               have_result,
    output logic               out_valid,
    input  logic               out_ready,
    output sobel_pkg::cmd_t    cmd,
    input  sobel_pkg::status_t status
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P1   = 3'd1;
    localparam logic [2:0] ST_P2   = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next      = state_reg;
        ov_next         = ov_reg;
        cmd             = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_P1;
                end
            end
            ST_P1: state_next = ST_P2;
            ST_P2:
            begin
                if (have_result)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!ov_next)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> state_reg == ST_P1)
        else $error("Accepted beat did not start the sequence.");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> out_valid)
        else $error("Finished result not presented.");
    assert property (@(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid)
        else $error("Stalled result dropped.");
endmodule
